// File: design/vmc_pkg.sv
// Shared types and codes for the vending machine controller.
package vmc_pkg;

	localparam int unsigned SLOT_BITS   = 2;
	localparam int unsigned AMOUNT_BITS = 14;
	localparam int unsigned COUNT_BITS  = 8;
	localparam int unsigned CREDIT_BITS = 16;
	localparam int unsigned PRICE_BITS  = 14;
	localparam int unsigned CFG_BITS    = 2;

	typedef enum logic [2:0] {
		ACT_INSERT   = 3'd0,
		ACT_SELECT   = 3'd1,
		ACT_CANCEL   = 3'd2,
		ACT_DISPENSE = 3'd3,
		ACT_RESTOCK  = 3'd4
	} action_t;

	typedef enum logic [3:0] {
		ST_ACCEPTED     = 4'd0,
		ST_INSERT_FIRST = 4'd1,
		ST_NO_CANCEL    = 4'd2,
		ST_SELECT_FIRST = 4'd3,
		ST_UNAVAILABLE  = 4'd4,
		ST_INSUFFICIENT = 4'd5,
		ST_DISPENSED    = 4'd6,
		ST_REFUNDED     = 4'd7,
		ST_RESTOCKED    = 4'd8
	} status_t;

	typedef struct packed {
		logic [2:0]             action;
		logic [AMOUNT_BITS-1:0] amount;
		logic [SLOT_BITS-1:0]   slot;
		logic [COUNT_BITS-1:0]  stock_count;
	} item_t;

	typedef struct packed {
		logic [3:0]             status;
		logic [CREDIT_BITS-1:0] balance_now;
		logic [CREDIT_BITS-1:0] money_returned;
		logic [SLOT_BITS-1:0]   dispensed_slot;
	} result_t;

	// Selected slot view handed to the step logic.
	typedef struct packed {
		logic                  exists;
		logic [COUNT_BITS-1:0] stock;
		logic [PRICE_BITS-1:0] price;
	} slot_view_t;

	// Next state and result produced by one transaction.
	typedef struct packed {
		logic                   holding;
		logic [CREDIT_BITS-1:0] credit;
		logic                   stock_we;
		logic [COUNT_BITS-1:0]  stock_val;
		result_t                result;
	} step_t;

endpackage

// File: design/vmc_step.sv
// Single-pass transaction logic: next mode, credit, stock write and result.
module vmc_step (
	input  vmc_pkg::item_t      item,
	input  logic                holding,
	input  logic [15:0]         credit,
	input  vmc_pkg::slot_view_t view,
	output vmc_pkg::step_t      step
);

	logic [16:0] sum;
	logic [15:0] price_ext;
	logic        short_credit;

	assign sum          = {1'b0, credit} + {3'b000, item.amount};
	assign price_ext    = {2'b00, view.price};
	assign short_credit = credit < price_ext;

	always_comb begin
		step                       = '0;
		step.holding               = holding;
		step.credit                = credit;
		step.stock_val             = item.stock_count;
		step.result.status         = vmc_pkg::ST_SELECT_FIRST;
		unique case (item.action)
			vmc_pkg::ACT_INSERT: begin
				step.credit        = sum[16] ? 16'hFFFF : sum[15:0];
				step.holding       = 1'b1;
				step.result.status = vmc_pkg::ST_ACCEPTED;
			end
			vmc_pkg::ACT_SELECT: begin
				if (!holding) begin
					step.result.status = vmc_pkg::ST_INSERT_FIRST;
				end else if (!view.exists || view.stock == '0) begin
					step.result.status = vmc_pkg::ST_UNAVAILABLE;
				end else if (short_credit) begin
					step.result.status = vmc_pkg::ST_INSUFFICIENT;
				end else begin
					step.stock_we              = 1'b1;
					step.stock_val             = view.stock - 8'd1;
					step.result.money_returned = credit - price_ext;
					step.credit                = '0;
					step.holding               = 1'b0;
					step.result.dispensed_slot = item.slot;
					step.result.status         = vmc_pkg::ST_DISPENSED;
				end
			end
			vmc_pkg::ACT_CANCEL: begin
				if (!holding) begin
					step.result.status = vmc_pkg::ST_NO_CANCEL;
				end else begin
					step.result.money_returned = credit;
					step.credit                = '0;
					step.holding               = 1'b0;
					step.result.status         = vmc_pkg::ST_REFUNDED;
				end
			end
			vmc_pkg::ACT_RESTOCK: begin
				if (view.exists) begin
					step.stock_we      = 1'b1;
					step.result.status = vmc_pkg::ST_RESTOCKED;
				end else begin
					step.result.status = vmc_pkg::ST_UNAVAILABLE;
				end
			end
			default: begin
				step.result.status = vmc_pkg::ST_SELECT_FIRST;
			end
		endcase
		step.result.balance_now = step.credit;
	end

endmodule

// File: design/vending_machine_controller.sv
// Vending machine controller top level.
// One result transaction is produced for every input transaction, in order. A new
// transaction can be taken every cycle while the input register is empty or passing its
// transaction on. It waits in the input register, then the mode, credit and slot
// stock are updated in a single pass while the result is loaded into the output register.
// A stalled result holds the output register, and the input register keeps taking a
// transaction as long as the result it would produce has a free place to go. Slot
// prices are written through the configuration channel, which is always ready;
// indexes at or past NUM_SLOTS are ignored.
module vending_machine_controller #(
	parameter int NUM_SLOTS = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  vmc_pkg::item_t                        item,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output vmc_pkg::result_t                      result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [vmc_pkg::CFG_BITS-1:0]          cfg_index,
	input  logic [vmc_pkg::PRICE_BITS-1:0]        cfg_data
);

	logic                                valid_s1;
	vmc_pkg::item_t                      item_s1;
	logic                                result_valid_q;
	vmc_pkg::result_t                    result_q;
	logic                                holding_q;
	logic [vmc_pkg::CREDIT_BITS-1:0]     credit_q;
	logic [vmc_pkg::COUNT_BITS-1:0]      stock_q [NUM_SLOTS];
	logic [vmc_pkg::PRICE_BITS-1:0]      price_q [NUM_SLOTS];
	logic                                advance;
	logic                                accept;
	vmc_pkg::slot_view_t                 view;
	vmc_pkg::step_t                      step;

	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	always_comb begin
		view = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (item_s1.slot == i[vmc_pkg::SLOT_BITS-1:0]) begin
				view.exists = 1'b1;
				view.stock  = stock_q[i];
				view.price  = price_q[i];
			end
		end
	end

	vmc_step u_step (
		.item    (item_s1),
		.holding (holding_q),
		.credit  (credit_q),
		.view    (view),
		.step    (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= step.result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding_q <= 1'b0;
			credit_q  <= '0;
		end else if (advance) begin
			holding_q <= step.holding;
			credit_q  <= step.credit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				stock_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (advance && step.stock_we &&
				    item_s1.slot == i[vmc_pkg::SLOT_BITS-1:0]) begin
					stock_q[i] <= step.stock_val;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				price_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (cfg_valid && cfg_ready &&
				    cfg_index == i[vmc_pkg::CFG_BITS-1:0]) begin
					price_q[i] <= cfg_data;
				end
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: design/vmc_checker.sv
// Port-level checks for the vending machine controller, bound to the top level.
module vmc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_stall,
	input vmc_pkg::result_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result transaction changed");

	a_sale_clears: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == vmc_pkg::ST_DISPENSED ||
		                 result.status == vmc_pkg::ST_REFUNDED)
		|-> result.balance_now == '0)
		else $error("balance not cleared after sale or refund");

	a_no_money: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != vmc_pkg::ST_DISPENSED &&
		result.status != vmc_pkg::ST_REFUNDED |-> result.money_returned == '0)
		else $error("money returned without sale or refund");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != vmc_pkg::ST_DISPENSED
		|-> result.dispensed_slot == '0)
		else $error("dispensed slot set without a sale");

endmodule

bind vending_machine_controller vmc_checker u_vmc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// File: tb/vending_machine_controller_tb.sv
// Self-checking testbench for the vending machine controller: sales, refunds, restock, prices.
`timescale 1ns / 1ps

module vending_machine_controller_tb;

	localparam int NUM_SLOTS = 4;
	localparam logic [vmc_pkg::CREDIT_BITS-1:0] CREDIT_MAX = '1;
	localparam int PRICE_TOP = 10000;
	localparam int RANDOM_PHASES = 4;
	// action codes with no defined operation
	localparam logic [2:0] ACT_SPARE_LO  = 3'd5;
	localparam logic [2:0] ACT_SPARE_MID = 3'd6;
	localparam logic [2:0] ACT_SPARE_HI  = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	vmc_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	vmc_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [vmc_pkg::CFG_BITS-1:0] cfg_index = '0;
	logic [vmc_pkg::PRICE_BITS-1:0] cfg_data = '0;

	// both sides run without gaps while set
	logic eager = 1'b0;
	int items_sent = 0;
	int settings_used = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	class vend_ledger;
		logic [vmc_pkg::PRICE_BITS-1:0] price [4];
		logic [vmc_pkg::COUNT_BITS-1:0] stock [4];
		logic holding;
		logic [vmc_pkg::CREDIT_BITS-1:0] credit;
		vmc_pkg::result_t receipts [$];
		int mismatches;
		int checked;
		int sales;
		int refunds;
		int rejected;

		function new();
			foreach (price[i]) begin
				price[i] = '0;
				stock[i] = '0;
			end
			holding = 1'b0;
			credit = '0;
			mismatches = 0;
			checked = 0;
			sales = 0;
			refunds = 0;
			rejected = 0;
		endfunction

		function void set_price(int idx, logic [vmc_pkg::PRICE_BITS-1:0] value);
			if (idx < NUM_SLOTS)
				price[idx] = value;
		endfunction

		function int pending();
			return receipts.size();
		endfunction

		// Predict the receipt for one accepted transaction and update the machine state.
		function void book(vmc_pkg::item_t it);
			vmc_pkg::result_t r;
			logic [vmc_pkg::CREDIT_BITS:0] sum;
			logic slot_ok;
			r = '0;
			r.status = vmc_pkg::ST_SELECT_FIRST;
			slot_ok = (int'(it.slot) < NUM_SLOTS);
			case (it.action)
				vmc_pkg::ACT_INSERT: begin
					sum = {1'b0, credit} + {3'b000, it.amount};
					credit = (sum > {1'b0, CREDIT_MAX}) ? CREDIT_MAX :
						sum[vmc_pkg::CREDIT_BITS-1:0];
					holding = 1'b1;
					r.status = vmc_pkg::ST_ACCEPTED;
				end
				vmc_pkg::ACT_SELECT: begin
					if (!holding) begin
						r.status = vmc_pkg::ST_INSERT_FIRST;
					end else if (!slot_ok || stock[it.slot] == '0) begin
						r.status = vmc_pkg::ST_UNAVAILABLE;
					end else if (credit < {2'b00, price[it.slot]}) begin
						r.status = vmc_pkg::ST_INSUFFICIENT;
					end else begin
						stock[it.slot] = stock[it.slot] - 8'd1;
						r.money_returned = credit - {2'b00, price[it.slot]};
						credit = '0;
						holding = 1'b0;
						r.dispensed_slot = it.slot;
						r.status = vmc_pkg::ST_DISPENSED;
					end
				end
				vmc_pkg::ACT_CANCEL: begin
					if (!holding) begin
						r.status = vmc_pkg::ST_NO_CANCEL;
					end else begin
						r.money_returned = credit;
						credit = '0;
						holding = 1'b0;
						r.status = vmc_pkg::ST_REFUNDED;
					end
				end
				vmc_pkg::ACT_RESTOCK: begin
					if (slot_ok) begin
						stock[it.slot] = it.stock_count;
						r.status = vmc_pkg::ST_RESTOCKED;
					end else begin
						r.status = vmc_pkg::ST_UNAVAILABLE;
					end
				end
				default: r.status = vmc_pkg::ST_SELECT_FIRST;
			endcase
			r.balance_now = credit;
			case (r.status) inside
				vmc_pkg::ST_DISPENSED: sales++;
				vmc_pkg::ST_REFUNDED: refunds++;
				vmc_pkg::ST_UNAVAILABLE, vmc_pkg::ST_INSUFFICIENT: rejected++;
				default: ;
			endcase
			receipts.push_back(r);
		endfunction

		function void check_field(string name, logic [vmc_pkg::CREDIT_BITS-1:0] want,
			logic [vmc_pkg::CREDIT_BITS-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void match(vmc_pkg::result_t got);
			vmc_pkg::result_t want;
			if (receipts.size() == 0) begin
				$error("unexpected result transaction, status %0d", got.status);
				mismatches++;
				return;
			end
			want = receipts.pop_front();
			checked++;
			check_field("status", {12'd0, want.status}, {12'd0, got.status});
			check_field("balance_now", want.balance_now, got.balance_now);
			check_field("money_returned", want.money_returned, got.money_returned);
			check_field("dispensed_slot", {14'd0, want.dispensed_slot},
				{14'd0, got.dispensed_slot});
		endfunction
	endclass

	vend_ledger ledger = new();

	vending_machine_controller #(
		.NUM_SLOTS(NUM_SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function automatic vmc_pkg::item_t make_item(logic [2:0] action, int amount, int slot,
		int count);
		vmc_pkg::item_t it;
		it.action = action;
		it.amount = amount[vmc_pkg::AMOUNT_BITS-1:0];
		it.slot = slot[vmc_pkg::SLOT_BITS-1:0];
		it.stock_count = count[vmc_pkg::COUNT_BITS-1:0];
		return it;
	endfunction

	// Mostly coin and select traffic so sales go through; restock keeps slots alive.
	function automatic vmc_pkg::item_t random_item();
		vmc_pkg::item_t it;
		int pick;
		pick = $urandom_range(0, 99);
		it.amount = 14'($urandom_range(0, 10000));
		it.slot = 2'($urandom_range(0, 3));
		it.stock_count = 8'($urandom_range(0, 255));
		if (pick < 38) begin
			it.action = vmc_pkg::ACT_INSERT;
			if ($urandom_range(0, 4) != 0)
				it.amount = 14'($urandom_range(0, 400));
		end else if (pick < 70) begin
			it.action = vmc_pkg::ACT_SELECT;
		end else if (pick < 78) begin
			it.action = vmc_pkg::ACT_CANCEL;
		end else if (pick < 92) begin
			it.action = vmc_pkg::ACT_RESTOCK;
			if ($urandom_range(0, 1) != 0)
				it.stock_count = 8'($urandom_range(0, 3));
		end else if (pick < 96) begin
			it.action = vmc_pkg::ACT_DISPENSE;
		end else begin
			it.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
		end
		return it;
	endfunction

	task automatic send_item(vmc_pkg::item_t it);
		int gap;
		gap = eager ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (item_stall !== 1'b0);
		ledger.book(it);
		items_sent++;
	endtask

	task automatic write_price(int idx, int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx[vmc_pkg::CFG_BITS-1:0];
		cfg_data <= value[vmc_pkg::PRICE_BITS-1:0];
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		ledger.set_price(idx, value[vmc_pkg::PRICE_BITS-1:0]);
	endtask

	task automatic set_prices(int p0, int p1, int p2, int p3);
		write_price(0, p0);
		write_price(1, p1);
		write_price(2, p2);
		write_price(3, p3);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Drain all pending receipts, then let the pipeline settle.
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (result_valid === 1'b1 && result_stall === 1'b0) begin
				ledger.match(result);
				hold_left = eager ? 0 : $urandom_range(0, 3);
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		#1000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int count;
		int cap;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		set_prices(0, PRICE_TOP, 250, 9999);
		send_item(make_item(vmc_pkg::ACT_SELECT, 0, 0, 0));
		send_item(make_item(vmc_pkg::ACT_CANCEL, 0, 1, 0));
		send_item(make_item(vmc_pkg::ACT_DISPENSE, 0, 2, 0));
		send_item(make_item(ACT_SPARE_LO, 10000, 3, 255));
		send_item(make_item(ACT_SPARE_MID, 0, 0, 0));
		send_item(make_item(ACT_SPARE_HI, 10000, 3, 255));
		send_item(make_item(vmc_pkg::ACT_INSERT, 0, 0, 0));
		send_item(make_item(vmc_pkg::ACT_SELECT, 0, 0, 0));
		send_item(make_item(vmc_pkg::ACT_RESTOCK, 0, 0, 255));
		send_item(make_item(vmc_pkg::ACT_RESTOCK, 0, 1, 1));
		send_item(make_item(vmc_pkg::ACT_RESTOCK, 0, 2, 128));
		send_item(make_item(vmc_pkg::ACT_RESTOCK, 0, 3, 255));
		send_item(make_item(vmc_pkg::ACT_SELECT, 0, 0, 0));
		// seven top coins push the credit into saturation
		repeat (7) send_item(make_item(vmc_pkg::ACT_INSERT, 10000, 0, 0));
		send_item(make_item(vmc_pkg::ACT_SELECT, 0, 1, 0));
		send_item(make_item(vmc_pkg::ACT_INSERT, 100, 0, 0));
		send_item(make_item(vmc_pkg::ACT_SELECT, 0, 1, 0));
		send_item(make_item(vmc_pkg::ACT_SELECT, 0, 3, 0));
		send_item(make_item(vmc_pkg::ACT_CANCEL, 0, 0, 0));

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: set_prices(0, 0, 0, 0);
				1: set_prices(PRICE_TOP, PRICE_TOP, PRICE_TOP, PRICE_TOP);
				2: set_prices(int'($urandom_range(0, 10000)), int'($urandom_range(0, 10000)),
					int'($urandom_range(0, 10000)), int'($urandom_range(0, 10000)));
				default: set_prices(int'($urandom_range(0, 500)), int'($urandom_range(0, 500)),
					int'($urandom_range(0, 500)), int'($urandom_range(0, 500)));
			endcase
			cap = (phase < 2) ? 300 : 350;
			for (count = 0; count < cap; count++) begin
				if (count % 50 == 0)
					eager <= ($urandom_range(0, 3) == 0);
				send_item(random_item());
			end
			eager <= 1'b0;
		end

		wait_idle();
		$display("Checked %0d results from %0d transactions under %0d price settings.",
			ledger.checked, items_sent, settings_used);
		$display("Sales %0d, refunds %0d, rejected selects and restocks %0d.",
			ledger.sales, ledger.refunds, ledger.rejected);
		if (ledger.mismatches == 0 && ledger.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
